// ----- sv/tsm_pkg.sv -----
package tsm_pkg;

  localparam int REG_COUNT    = 256;
  localparam int MAX_READ_LEN = 16;

  localparam int AddrW    = $clog2(REG_COUNT);
  localparam int CntW     = $clog2(MAX_READ_LEN + 1);
  localparam int DataW    = 8;
  localparam int KindW    = 3;
  localparam int DevAddrW = 7;
  localparam int LenW     = 5;
  localparam int RandW    = 32;
  localparam int TempCfgW = 15;
  localparam int TempW    = 16;
  localparam int StatusW  = 2;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 15;

  localparam logic [CfgIdxW-1:0] CFG_DEV_ADDR = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_MIN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_TEMP_MAX = 2'd2;

  localparam logic [DevAddrW-1:0] DEV_ADDR_RESET = 7'h76;
  localparam logic [TempCfgW-1:0] TEMP_MIN_RESET = 15'd20000;
  localparam logic [TempCfgW-1:0] TEMP_MAX_RESET = 15'd30000;
  localparam logic [TempW-1:0]    TEMP_RESET     = 16'd25000;

  localparam int STEP_MOD    = 1000;
  localparam int STEP_OFFSET = 500;

  localparam logic [AddrW-1:0] ADDR_ID    = 8'hD0;
  localparam logic [AddrW-1:0] ADDR_CTRL  = 8'hF4;
  localparam logic [AddrW-1:0] ADDR_TMSB  = 8'hFA;
  localparam logic [AddrW-1:0] ADDR_TLSB  = 8'hFB;
  localparam logic [AddrW-1:0] ADDR_TXLSB = 8'hFC;

  localparam logic [DataW-1:0] ID_VALUE   = 8'h58;
  localparam logic [DataW-1:0] CTRL_VALUE = 8'h27;

  typedef enum logic [KindW-1:0] {
    KIND_MSG_WR    = 3'd0,
    KIND_MSG_RD    = 3'd1,
    KIND_SMB_QUICK = 3'd2,
    KIND_SMB_RD    = 3'd3,
    KIND_SMB_WR    = 3'd4,
    KIND_SMB_OTHER = 3'd5,
    KIND_TICK      = 3'd6
  } tsm_kind_e;

  typedef enum logic [StatusW-1:0] {
    STAT_OK      = 2'd0,
    STAT_NO_DEV  = 2'd1,
    STAT_NOT_SUP = 2'd2,
    STAT_SKIPPED = 2'd3
  } tsm_status_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RD_REQ,
    ST_RD_OUT,
    ST_STAT,
    ST_MOD,
    ST_CLAMP,
    ST_WR_MSB,
    ST_WR_LSB,
    ST_WR_XLSB
  } tsm_state_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_STATUS,
    OP_MSG_RD,
    OP_SMB_RD,
    OP_TICK
  } tsm_op_e;

  typedef enum logic [1:0] {
    WSEL_ITEM,
    WSEL_TMSB,
    WSEL_TLSB,
    WSEL_TXLSB
  } tsm_wsel_e;

  typedef enum logic {
    RSEL_PTR,
    RSEL_IDX
  } tsm_rsel_e;

  typedef struct packed {
    logic      ready;
    logic      load;
    logic      exec;
    logic      mem_we;
    tsm_wsel_e wsel;
    tsm_rsel_e rsel;
    logic      out_stat;
    logic      out_data;
    logic      mod_step;
    logic      clamp;
  } tsm_cmd_t;

  typedef struct packed {
    logic    in_valid;
    tsm_op_e op;
    logic    store;
    logic    is_smb;
    logic    out_free;
    logic    rd_last;
    logic    mod_last;
  } tsm_sts_t;

  function automatic logic [DataW-1:0] temp_msb(input logic [TempW-1:0] t);
    return {4'b0, t[15:12]};
  endfunction

  function automatic logic [DataW-1:0] temp_lsb(input logic [TempW-1:0] t);
    return t[11:4];
  endfunction

  function automatic logic [DataW-1:0] temp_xlsb(input logic [TempW-1:0] t);
    return {t[3:0], 4'b0};
  endfunction

  function automatic logic [DataW-1:0] reg_reset_value(input logic [AddrW-1:0] a);
    logic [DataW-1:0] v;
    case (a)
      ADDR_ID:    v = ID_VALUE;
      ADDR_CTRL:  v = CTRL_VALUE;
      ADDR_TMSB:  v = temp_msb(TEMP_RESET);
      ADDR_TLSB:  v = temp_lsb(TEMP_RESET);
      ADDR_TXLSB: v = temp_xlsb(TEMP_RESET);
      default:    v = '0;
    endcase
    return v;
  endfunction

endpackage

// ----- sv/tsm_if.sv -----
interface tsm_in_if import tsm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KindW-1:0]    kind;
  logic [DevAddrW-1:0] dev_addr;
  logic                start_of_transfer;
  logic [LenW-1:0]     msg_len;
  logic [AddrW-1:0]    reg_index;
  logic [DataW-1:0]    data_byte;
  logic [RandW-1:0]    random_value;

  modport source (
    output valid, kind, dev_addr, start_of_transfer, msg_len, reg_index, data_byte,
           random_value,
    input  ready
  );
  modport sink (
    input  valid, kind, dev_addr, start_of_transfer, msg_len, reg_index, data_byte,
           random_value,
    output ready
  );
endinterface

interface tsm_out_if import tsm_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [DataW-1:0]   read_data;
  logic [StatusW-1:0] status;
  logic               last;

  modport source (output valid, read_data, status, last, input ready);
  modport sink (input valid, read_data, status, last, output ready);
endinterface

// ----- sv/tsm_regfile.sv -----
module tsm_regfile import tsm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [DataW-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [DataW-1:0] rdata_o
);

  logic [DataW-1:0]     mem [REG_COUNT];
  logic [REG_COUNT-1:0] written_q;
  logic [DataW-1:0]     rd_q;
  logic [AddrW-1:0]     raddr_q;
  logic                 rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rd_q    <= mem[raddr_i];
    raddr_q <= raddr_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q <= '0;
      rvalid_q  <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      rvalid_q <= written_q[raddr_i];
    end
  end

  // Entries never written read back as their power-on contents.
  assign rdata_o = rvalid_q ? rd_q : reg_reset_value(raddr_q);

endmodule

// ----- sv/tsm_datapath.sv -----
module tsm_datapath import tsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  tsm_in_if.sink              in_i,
  tsm_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  tsm_cmd_t            cmd_i,
  output tsm_sts_t            sts_o,
  output logic                mem_we_o,
  output logic [AddrW-1:0]    mem_waddr_o,
  output logic [DataW-1:0]    mem_wdata_o,
  output logic [AddrW-1:0]    mem_raddr_o,
  input  logic [DataW-1:0]    mem_rdata_i
);

  localparam int FoldW     = 10;
  localparam int FoldMul   = (1 << FoldW) - STEP_MOD;
  localparam int FoldSteps = 5;
  localparam int RemW      = $clog2(STEP_MOD);
  localparam int BitCntW   = $clog2(FoldSteps + 1);
  localparam int SumW      = TempW + 2;

  logic [DevAddrW-1:0] dev_addr_q;
  logic [TempCfgW-1:0] temp_min_q;
  logic [TempCfgW-1:0] temp_max_q;

  logic [KindW-1:0]    kind_q;
  logic [DevAddrW-1:0] addr_q;
  logic                sot_q;
  logic [LenW-1:0]     len_q;
  logic [AddrW-1:0]    idx_q;
  logic [DataW-1:0]    dat_q;
  logic [RandW-1:0]    rnd_q, rnd_d;

  logic [AddrW-1:0]    ptr_q, ptr_d;
  logic [TempW-1:0]    temp_q, temp_d;
  logic                failed_q, failed_d;
  tsm_status_e         resp_q, resp;

  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [BitCntW-1:0]  bitcnt_q, bitcnt_d;
  logic [RemW-1:0]     rem_q, rem_d;

  logic                out_valid_q, out_valid_d;
  logic [DataW-1:0]    out_data_q;
  logic [StatusW-1:0]  out_status_q;
  logic                out_last_q;

  logic                match, is_msg, is_smb, eff_failed, msg_ok;
  tsm_op_e             op;
  logic                store;
  logic [CntW-1:0]     rd_len;
  logic                rd_last;
  logic signed [SumW-1:0] t_sum, t_hi, t_lo;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= DEV_ADDR_RESET;
      temp_min_q <= TEMP_MIN_RESET;
      temp_max_q <= TEMP_MAX_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEV_ADDR: dev_addr_q <= cfg_data_i[DevAddrW-1:0];
        CFG_TEMP_MIN: temp_min_q <= cfg_data_i[TempCfgW-1:0];
        CFG_TEMP_MAX: temp_max_q <= cfg_data_i[TempCfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= in_i.kind;
      addr_q <= in_i.dev_addr;
      sot_q  <= in_i.start_of_transfer;
      len_q  <= in_i.msg_len;
      idx_q  <= in_i.reg_index;
      dat_q  <= in_i.data_byte;
    end
    if (cmd_i.exec) begin
      resp_q <= resp;
    end
    rnd_q <= rnd_d;
    rem_q <= rem_d;
  end

  always_comb begin
    match      = (addr_q == dev_addr_q);
    is_msg     = (kind_q == KIND_MSG_WR) || (kind_q == KIND_MSG_RD);
    is_smb     = (kind_q == KIND_SMB_QUICK) || (kind_q == KIND_SMB_RD) ||
                 (kind_q == KIND_SMB_WR) || (kind_q == KIND_SMB_OTHER);
    eff_failed = failed_q && !sot_q;
    msg_ok     = is_msg && !eff_failed && match;

    if (is_msg && eff_failed) begin
      resp = STAT_SKIPPED;
    end else if (!match) begin
      resp = STAT_NO_DEV;
    end else if (kind_q == KIND_SMB_OTHER) begin
      resp = STAT_NOT_SUP;
    end else begin
      resp = STAT_OK;
    end

    if (is_msg) begin
      op = (msg_ok && (kind_q == KIND_MSG_RD) && (len_q != '0)) ? OP_MSG_RD : OP_STATUS;
    end else if (is_smb) begin
      op = (match && (kind_q == KIND_SMB_RD)) ? OP_SMB_RD : OP_STATUS;
    end else if (kind_q == KIND_TICK) begin
      op = OP_TICK;
    end else begin
      op = OP_NONE;
    end

    store = (msg_ok && (kind_q == KIND_MSG_WR) && (len_q >= LenW'(2))) ||
            (is_smb && match && (kind_q == KIND_SMB_WR));

    if (int'(len_q) > MAX_READ_LEN) begin
      rd_len = CntW'(MAX_READ_LEN);
    end else begin
      rd_len = CntW'(len_q);
    end
    rd_last = is_smb || ((cnt_q + CntW'(1)) == rd_len);
  end

  always_comb begin
    ptr_d    = ptr_q;
    failed_d = failed_q;
    if (cmd_i.exec && is_msg) begin
      failed_d = eff_failed || !match;
      if (msg_ok && (kind_q == KIND_MSG_WR) && (len_q != '0)) begin
        ptr_d = idx_q;
      end
    end
  end

  // The random word is folded at bit ten five times, since 1024 leaves 24 over the step
  // range, and the last step subtracts the range once to give the remainder.
  always_comb begin
    rnd_d    = rnd_q;
    rem_d    = rem_q;
    bitcnt_d = bitcnt_q;
    if (cmd_i.load) begin
      rnd_d    = in_i.random_value;
      rem_d    = '0;
      bitcnt_d = '0;
    end else if (cmd_i.mod_step) begin
      rnd_d    = RandW'(rnd_q[RandW-1:FoldW]) * RandW'(FoldMul) +
                 RandW'(rnd_q[FoldW-1:0]);
      bitcnt_d = bitcnt_q + BitCntW'(1);
      if (rnd_q >= RandW'(STEP_MOD)) begin
        rem_d = RemW'(rnd_q - RandW'(STEP_MOD));
      end else begin
        rem_d = RemW'(rnd_q);
      end
    end
  end

  always_comb begin
    t_sum  = $signed({2'b0, temp_q}) + $signed(SumW'(rem_q)) - $signed(SumW'(STEP_OFFSET));
    t_hi   = (t_sum > $signed(SumW'(temp_max_q))) ? $signed(SumW'(temp_max_q)) : t_sum;
    t_lo   = (t_hi < $signed(SumW'(temp_min_q))) ? $signed(SumW'(temp_min_q)) : t_hi;
    temp_d = cmd_i.clamp ? t_lo[TempW-1:0] : temp_q;
  end

  always_comb begin
    cnt_d = cnt_q;
    if (cmd_i.load) begin
      cnt_d = '0;
    end else if (cmd_i.out_data) begin
      cnt_d = cnt_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      temp_q      <= TEMP_RESET;
      failed_q    <= 1'b0;
      cnt_q       <= '0;
      bitcnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      ptr_q       <= ptr_d;
      temp_q      <= temp_d;
      failed_q    <= failed_d;
      cnt_q       <= cnt_d;
      bitcnt_q    <= bitcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q && !out_o.ready;
    if (cmd_i.out_stat || cmd_i.out_data) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_stat) begin
      out_data_q   <= '0;
      out_status_q <= resp_q;
      out_last_q   <= 1'b1;
    end else if (cmd_i.out_data) begin
      out_data_q   <= mem_rdata_i;
      out_status_q <= STAT_OK;
      out_last_q   <= rd_last;
    end
  end

  always_comb begin
    mem_we_o = cmd_i.mem_we;
    case (cmd_i.wsel)
      WSEL_ITEM: begin
        mem_waddr_o = idx_q;
        mem_wdata_o = dat_q;
      end
      WSEL_TMSB: begin
        mem_waddr_o = ADDR_TMSB;
        mem_wdata_o = temp_msb(temp_q);
      end
      WSEL_TLSB: begin
        mem_waddr_o = ADDR_TLSB;
        mem_wdata_o = temp_lsb(temp_q);
      end
      WSEL_TXLSB: begin
        mem_waddr_o = ADDR_TXLSB;
        mem_wdata_o = temp_xlsb(temp_q);
      end
      default: begin
        mem_waddr_o = idx_q;
        mem_wdata_o = dat_q;
      end
    endcase
    mem_raddr_o = (cmd_i.rsel == RSEL_IDX) ? idx_q : ptr_q + AddrW'(cnt_q);
  end

  assign in_i.ready      = cmd_i.ready;
  assign out_o.valid     = out_valid_q;
  assign out_o.read_data = out_data_q;
  assign out_o.status    = out_status_q;
  assign out_o.last      = out_last_q;

  assign sts_o.in_valid = in_i.valid;
  assign sts_o.op       = op;
  assign sts_o.store    = store;
  assign sts_o.is_smb   = is_smb;
  assign sts_o.out_free = !out_valid_q || out_o.ready;
  assign sts_o.rd_last  = rd_last;
  assign sts_o.mod_last = (bitcnt_q == BitCntW'(FoldSteps));

endmodule

// ----- sv/tsm_ctrl.sv -----
module tsm_ctrl import tsm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  tsm_sts_t sts_i,
  output tsm_cmd_t cmd_o
);

  tsm_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (sts_i.in_valid) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (sts_i.op)
          OP_STATUS: state_d = ST_STAT;
          OP_MSG_RD: state_d = ST_RD_REQ;
          OP_SMB_RD: state_d = ST_RD_OUT;
          OP_TICK:   state_d = ST_MOD;
          default:   state_d = ST_IDLE;
        endcase
      end
      ST_RD_REQ: state_d = ST_RD_OUT;
      ST_RD_OUT: begin
        if (sts_i.out_free) begin
          state_d = sts_i.rd_last ? ST_IDLE : ST_RD_REQ;
        end
      end
      ST_STAT: begin
        if (sts_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (sts_i.mod_last) begin
          state_d = ST_CLAMP;
        end
      end
      ST_CLAMP:   state_d = ST_WR_MSB;
      ST_WR_MSB:  state_d = ST_WR_LSB;
      ST_WR_LSB:  state_d = ST_WR_XLSB;
      ST_WR_XLSB: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    cmd_o.wsel = WSEL_ITEM;
    cmd_o.rsel = sts_i.is_smb ? RSEL_IDX : RSEL_PTR;
    case (state_q)
      ST_IDLE: begin
        cmd_o.ready = 1'b1;
        cmd_o.load  = sts_i.in_valid;
      end
      ST_EXEC: begin
        cmd_o.exec   = 1'b1;
        cmd_o.mem_we = sts_i.store;
      end
      ST_RD_OUT: begin
        cmd_o.out_data = sts_i.out_free;
      end
      ST_STAT: begin
        cmd_o.out_stat = sts_i.out_free;
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
      end
      ST_CLAMP: begin
        cmd_o.clamp = 1'b1;
      end
      ST_WR_MSB: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WSEL_TMSB;
      end
      ST_WR_LSB: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WSEL_TLSB;
      end
      ST_WR_XLSB: begin
        cmd_o.mem_we = 1'b1;
        cmd_o.wsel   = WSEL_TXLSB;
      end
      default: ;
    endcase
  end

endmodule

// ----- sv/i2c_temperature_sensor_model.sv -----
// A status or SMBus read result is registered after its item is taken, via the execute
// state and the status or read-out state; each byte of a message read passes the
// read-request and read-out states. One item is worked on at a time; a tick runs the
// six-step remainder, a clamp and three register writes.
// Reset is asynchronous, active low, and restores the register file contents,
// pointer, temperature, failure flag and configuration at once.
module i2c_temperature_sensor_model import tsm_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  tsm_in_if.sink              in_i,
  tsm_out_if.source           out_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  tsm_cmd_t         cmd;
  tsm_sts_t         sts;
  logic             mem_we;
  logic [AddrW-1:0] mem_waddr;
  logic [DataW-1:0] mem_wdata;
  logic [AddrW-1:0] mem_raddr;
  logic [DataW-1:0] mem_rdata;
  logic             in_acc;

  tsm_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  tsm_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  tsm_regfile u_regfile (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign in_acc = in_i.valid && in_i.ready;

  a_tick_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (in_i.kind == KIND_TICK) && !out_o.valid |=> !out_o.valid)
    else $error("A tick item produced a result.");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("A second item was taken while one was still in work.");

  a_write_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> !in_i.ready)
    else $error("The register file was written while the block was idle.");

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.out_stat || cmd.out_data) |-> (!out_o.valid || out_o.ready))
    else $error("A result overwrote one that was not yet taken.");

endmodule

// ----- tb/i2c_temperature_sensor_model_tb.sv -----
`timescale 1ns / 1ps

module i2c_temperature_sensor_model_tb;
  import tsm_pkg::*;

  typedef struct packed {
    logic [KindW-1:0]    kind;
    logic [DevAddrW-1:0] dev_addr;
    logic                sot;
    logic [LenW-1:0]     len;
    logic [AddrW-1:0]    idx;
    logic [DataW-1:0]    dat;
    logic [RandW-1:0]    rnd;
  } sensor_access_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    tsm_status_e      status;
    logic             last;
  } sensor_reply_t;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles   = 60;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;

  tsm_in_if  in_if ();
  tsm_out_if out_if ();

  i2c_temperature_sensor_model dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_if),
    .out_o      (out_if),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i)
  );

  // Shadow copy of the sensor state and its configuration.
  logic [DataW-1:0]    sensor_regs [REG_COUNT];
  logic [AddrW-1:0]    sensor_ptr;
  logic [TempW-1:0]    sensor_temp;
  logic                sensor_failed;
  logic [DevAddrW-1:0] sensor_dev_addr;
  logic [TempCfgW-1:0] sensor_temp_min;
  logic [TempCfgW-1:0] sensor_temp_max;

  sensor_access_t pending_accesses [$];
  sensor_reply_t  expected_replies [$];

  int   mismatch_count;
  int   accepted_accesses;
  int   checked_replies;
  int   tick_count;
  int   burst_left;
  int   gap_left;
  logic in_take;
  int   stall_phase;
  int   stall_mode;
  logic [7:0] stall_mask;
  int   idle_cycles;
  sensor_reply_t got_expected;

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic void pack_sensor_temp();
    sensor_regs[ADDR_TMSB]  = {4'b0, sensor_temp[15:12]};
    sensor_regs[ADDR_TLSB]  = sensor_temp[11:4];
    sensor_regs[ADDR_TXLSB] = {sensor_temp[3:0], 4'b0};
  endfunction

  function automatic void reset_sensor();
    for (int a = 0; a < REG_COUNT; a++) begin
      sensor_regs[a] = '0;
    end
    sensor_regs[ADDR_ID]   = ID_VALUE;
    sensor_regs[ADDR_CTRL] = CTRL_VALUE;
    sensor_ptr      = '0;
    sensor_temp     = TEMP_RESET;
    sensor_failed   = 1'b0;
    sensor_dev_addr = DEV_ADDR_RESET;
    sensor_temp_min = TEMP_MIN_RESET;
    sensor_temp_max = TEMP_MAX_RESET;
    pack_sensor_temp();
  endfunction

  function automatic void expect_reply(logic [DataW-1:0] d, tsm_status_e s, logic l);
    sensor_reply_t r;
    r.read_data = d;
    r.status    = s;
    r.last      = l;
    expected_replies.push_back(r);
  endfunction

  function automatic void emulate_access(sensor_access_t a);
    logic match;
    int   n;
    int   t;
    match = (a.dev_addr == sensor_dev_addr);
    case (a.kind)
      KIND_MSG_WR, KIND_MSG_RD: begin
        if (a.sot) sensor_failed = 1'b0;
        if (sensor_failed) begin
          expect_reply('0, STAT_SKIPPED, 1'b1);
        end else if (!match) begin
          sensor_failed = 1'b1;
          expect_reply('0, STAT_NO_DEV, 1'b1);
        end else if (a.kind == KIND_MSG_WR) begin
          if (a.len >= 1) sensor_ptr = a.idx;
          if (a.len >= 2) sensor_regs[sensor_ptr] = a.dat;
          expect_reply('0, STAT_OK, 1'b1);
        end else if (a.len == 0) begin
          expect_reply('0, STAT_OK, 1'b1);
        end else begin
          n = (a.len > MAX_READ_LEN) ? MAX_READ_LEN : int'(a.len);
          for (int i = 0; i < n; i++) begin
            expect_reply(sensor_regs[AddrW'(sensor_ptr + i)], STAT_OK, i == n - 1);
          end
        end
      end
      KIND_SMB_QUICK, KIND_SMB_RD, KIND_SMB_WR, KIND_SMB_OTHER: begin
        if (!match) begin
          expect_reply('0, STAT_NO_DEV, 1'b1);
        end else if (a.kind == KIND_SMB_RD) begin
          expect_reply(sensor_regs[a.idx], STAT_OK, 1'b1);
        end else if (a.kind == KIND_SMB_WR) begin
          sensor_regs[a.idx] = a.dat;
          expect_reply('0, STAT_OK, 1'b1);
        end else if (a.kind == KIND_SMB_OTHER) begin
          expect_reply('0, STAT_NOT_SUP, 1'b1);
        end else begin
          expect_reply('0, STAT_OK, 1'b1);
        end
      end
      KIND_TICK: begin
        t = int'(sensor_temp) + int'(a.rnd % RandW'(STEP_MOD)) - STEP_OFFSET;
        if (t > int'(sensor_temp_max)) t = int'(sensor_temp_max);
        if (t < int'(sensor_temp_min)) t = int'(sensor_temp_min);
        sensor_temp = t[TempW-1:0];
        pack_sensor_temp();
        tick_count++;
      end
      default: ;
    endcase
  endfunction

  task automatic push_access(input logic [KindW-1:0] kind, input logic [DevAddrW-1:0] dev,
                             input logic sot, input logic [LenW-1:0] len,
                             input logic [AddrW-1:0] idx, input logic [DataW-1:0] dat,
                             input logic [RandW-1:0] rnd);
    sensor_access_t a;
    a.kind     = kind;
    a.dev_addr = dev;
    a.sot      = sot;
    a.len      = len;
    a.idx      = idx;
    a.dat      = dat;
    a.rnd      = rnd;
    pending_accesses.push_back(a);
  endtask

  function automatic logic [DevAddrW-1:0] pick_dev();
    logic [DevAddrW-1:0] d;
    if ($urandom_range(0, 9) != 0) return sensor_dev_addr;
    d = DevAddrW'($urandom_range(0, 127));
    if (d == sensor_dev_addr) d = d ^ 7'd1;
    return d;
  endfunction

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEV_ADDR: sensor_dev_addr = value[DevAddrW-1:0];
      CFG_TEMP_MIN: sensor_temp_min = value[TempCfgW-1:0];
      CFG_TEMP_MAX: sensor_temp_max = value[TempCfgW-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [DevAddrW-1:0] dev, input logic [TempCfgW-1:0] tmin,
                            input logic [TempCfgW-1:0] tmax);
    write_reg(CFG_DEV_ADDR, CfgDataW'(dev));
    write_reg(CFG_TEMP_MIN, CfgDataW'(tmin));
    write_reg(CFG_TEMP_MAX, CfgDataW'(tmax));
  endtask

  task automatic wait_idle();
    while (pending_accesses.size() > 0 || expected_replies.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic queue_directed();
    logic [DevAddrW-1:0] a;
    a = DEV_ADDR_RESET;
    push_access(KIND_SMB_RD, a, 1'b0, 5'd0, ADDR_ID, 8'h00, 32'h0);
    push_access(KIND_SMB_RD, a, 1'b0, 5'd0, ADDR_CTRL, 8'h00, 32'h0);
    push_access(KIND_MSG_WR, a, 1'b1, 5'd1, ADDR_TMSB, 8'h00, 32'h0);
    push_access(KIND_MSG_RD, a, 1'b0, 5'd3, 8'h00, 8'h00, 32'h0);
    push_access(KIND_TICK, a, 1'b0, 5'd0, 8'h00, 8'h00, 32'd0);
    push_access(KIND_TICK, a, 1'b0, 5'd0, 8'h00, 8'h00, 32'd999);
    push_access(KIND_TICK, a, 1'b1, 5'd31, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    push_access(KIND_MSG_RD, a, 1'b1, 5'd3, 8'h00, 8'h00, 32'h0);
    push_access(KIND_MSG_WR, a, 1'b1, 5'd2, 8'hFF, 8'hFF, 32'h0);
    push_access(KIND_MSG_WR, a, 1'b0, 5'd16, 8'h00, 8'h00, 32'h0);
    push_access(KIND_MSG_WR, a, 1'b1, 5'd0, 8'h55, 8'hAA, 32'h0);
    push_access(KIND_MSG_WR, a, 1'b1, 5'd1, 8'hF8, 8'h00, 32'h0);
    push_access(KIND_MSG_RD, a, 1'b0, 5'd16, 8'h00, 8'h00, 32'h0);
    push_access(KIND_MSG_RD, a, 1'b1, 5'd0, 8'h00, 8'h00, 32'h0);
    push_access(KIND_MSG_RD, a, 1'b1, 5'd1, 8'h00, 8'h00, 32'h0);
    push_access(KIND_SMB_QUICK, a, 1'b0, 5'd0, 8'h00, 8'h00, 32'h0);
    push_access(KIND_SMB_WR, a, 1'b0, 5'd0, 8'h00, 8'hA5, 32'h0);
    push_access(KIND_SMB_RD, a, 1'b0, 5'd0, 8'h00, 8'h00, 32'h0);
    push_access(KIND_SMB_OTHER, a, 1'b0, 5'd0, 8'h00, 8'h00, 32'h0);
    push_access(KIND_MSG_WR, 7'h00, 1'b1, 5'd2, 8'h10, 8'h33, 32'h0);
    push_access(KIND_MSG_RD, a, 1'b0, 5'd4, 8'h00, 8'h00, 32'h0);
    push_access(KIND_SMB_QUICK, a, 1'b0, 5'd0, 8'h00, 8'h00, 32'h0);
    push_access(KIND_MSG_WR, a, 1'b0, 5'd2, 8'h20, 8'h44, 32'h0);
    push_access(KIND_SMB_OTHER, 7'h7F, 1'b0, 5'd0, 8'h00, 8'h00, 32'h0);
    push_access(KIND_SMB_RD, 7'h7F, 1'b0, 5'd0, ADDR_ID, 8'h00, 32'h0);
    push_access(KIND_MSG_RD, a, 1'b1, 5'd16, 8'h00, 8'h00, 32'h0);
  endtask

  // Mostly pointer-write-then-read transfers, with SMBus accesses, ticks and
  // loose message items mixed in.
  task automatic queue_random(input int count);
    int made;
    int pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        push_access(KIND_MSG_WR, pick_dev(), 1'b1, LenW'($urandom_range(1, 2)),
                    AddrW'($urandom), DataW'($urandom), $urandom);
        push_access(KIND_MSG_RD, pick_dev(), 1'b0, LenW'($urandom_range(0, MAX_READ_LEN)),
                    AddrW'($urandom), DataW'($urandom), $urandom);
        made += 2;
      end else if (pick < 8) begin
        push_access(KindW'($urandom_range(KIND_SMB_QUICK, KIND_SMB_OTHER)), pick_dev(),
                    1'($urandom), LenW'($urandom_range(0, MAX_READ_LEN)),
                    AddrW'($urandom), DataW'($urandom), $urandom);
        made++;
      end else if (pick == 8) begin
        push_access(KIND_TICK, pick_dev(), 1'($urandom), LenW'($urandom_range(0, MAX_READ_LEN)),
                    AddrW'($urandom), DataW'($urandom), $urandom);
        made++;
      end else begin
        push_access(KindW'($urandom_range(KIND_MSG_WR, KIND_MSG_RD)), pick_dev(),
                    1'($urandom), LenW'($urandom_range(0, MAX_READ_LEN)),
                    AddrW'($urandom), DataW'($urandom), $urandom);
        made++;
      end
    end
  endtask

  // Sender: bursts of random length separated by random gaps.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      burst_left  = $urandom_range(1, 12);
      gap_left    = 0;
    end else begin
      in_take = in_if.valid && in_if.ready;
      if (in_take) begin
        emulate_access(pending_accesses.pop_front());
        accepted_accesses++;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
      if (in_if.valid && !in_take) begin
      end else if (gap_left > 0) begin
        in_if.valid <= 1'b0;
        gap_left--;
      end else if (pending_accesses.size() > 0) begin
        in_if.valid             <= 1'b1;
        in_if.kind              <= pending_accesses[0].kind;
        in_if.dev_addr          <= pending_accesses[0].dev_addr;
        in_if.start_of_transfer <= pending_accesses[0].sot;
        in_if.msg_len           <= pending_accesses[0].len;
        in_if.reg_index         <= pending_accesses[0].idx;
        in_if.data_byte         <= pending_accesses[0].dat;
        in_if.random_value      <= pending_accesses[0].rnd;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall pattern is chosen anew periodically among always ready,
  // random stalls and a repeating 8-bit mask.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_phase  = 0;
      stall_mode   = 0;
      stall_mask   = 8'hFF;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: read_data %0h status %0d last %0b",
                 out_if.read_data, out_if.status, out_if.last);
          mismatch_count++;
        end else begin
          got_expected = expected_replies.pop_front();
          checked_replies++;
          if (out_if.read_data !== got_expected.read_data) begin
            $error("read_data: expected %0h, actual %0h", got_expected.read_data,
                   out_if.read_data);
            mismatch_count++;
          end
          if (out_if.status !== got_expected.status) begin
            $error("status: expected %0d, actual %0d", got_expected.status, out_if.status);
            mismatch_count++;
          end
          if (out_if.last !== got_expected.last) begin
            $error("last: expected %0b, actual %0b", got_expected.last, out_if.last);
            mismatch_count++;
          end
        end
      end
      if (stall_phase == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_mask = 8'($urandom_range(1, 255));
      end
      stall_phase = (stall_phase + 1) % 64;
      case (stall_mode)
        0:       out_if.ready <= 1'b1;
        1:       out_if.ready <= ($urandom_range(0, 3) != 0);
        default: out_if.ready <= stall_mask[stall_phase % 8];
      endcase
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= WatchdogLimit) begin
        $error("watchdog: no item moved for %0d cycles", WatchdogLimit);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    rst_ni                   = 1'b0;
    cfg_we_i                 = 1'b0;
    cfg_idx_i                = CFG_DEV_ADDR;
    cfg_data_i               = '0;
    in_if.valid              = 1'b0;
    in_if.kind               = KIND_MSG_WR;
    in_if.dev_addr           = '0;
    in_if.start_of_transfer  = 1'b0;
    in_if.msg_len            = '0;
    in_if.reg_index          = '0;
    in_if.data_byte          = '0;
    in_if.random_value       = '0;
    out_if.ready             = 1'b0;
    mismatch_count           = 0;
    accepted_accesses        = 0;
    checked_replies          = 0;
    tick_count               = 0;
    idle_cycles              = 0;
    reset_sensor();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    queue_directed();
    wait_idle();
    set_config(7'h00, 15'd0, 15'h7FFF);
    queue_random(19);
    wait_idle();
    set_config(7'h7F, 15'h7FFF, 15'd0);
    queue_random(19);
    wait_idle();
    set_config(DevAddrW'($urandom), TempCfgW'($urandom), TempCfgW'($urandom));
    queue_random(19);
    wait_idle();
    set_config(DEV_ADDR_RESET, TEMP_MIN_RESET, TEMP_MAX_RESET);
    queue_random(19);
    wait_idle();

    $display("Sent %0d items (%0d ticks) under five register settings; checked %0d replies.",
             accepted_accesses, tick_count, checked_replies);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
